/* sv/p256fr_pkg.sv */
// Shared types, constants and the term schedule of the P-256 fast reduction core.
`timescale 1ns / 1ps

package p256fr_pkg;

	localparam int NCOL  = 8;
	localparam int NTERM = 9;

	localparam logic [2:0] LAST_COL  = 3'd7;
	localparam logic [3:0] LAST_TERM = 4'd8;
	localparam logic [1:0] LAST_EMIT = 2'd3;

	// Source index 16 selects a zero word.
	localparam logic [4:0] ZW = 5'd16;

	// Source 32-bit product word for each term and column, least significant column first.
	localparam logic [4:0] TERM_SRC [NTERM][NCOL] = '{
		'{5'd0,  5'd1,  5'd2,  5'd3,  5'd4,  5'd5,  5'd6,  5'd7 },
		'{ZW,    ZW,    ZW,    5'd11, 5'd12, 5'd13, 5'd14, 5'd15},
		'{ZW,    ZW,    ZW,    5'd12, 5'd13, 5'd14, 5'd15, ZW   },
		'{5'd8,  5'd9,  5'd10, ZW,    ZW,    ZW,    5'd14, 5'd15},
		'{5'd9,  5'd10, 5'd11, 5'd13, 5'd14, 5'd15, 5'd13, 5'd8 },
		'{5'd11, 5'd12, 5'd13, ZW,    ZW,    ZW,    5'd8,  5'd10},
		'{5'd12, 5'd13, 5'd14, 5'd15, ZW,    ZW,    5'd9,  5'd11},
		'{5'd13, 5'd14, 5'd15, 5'd8,  5'd9,  5'd10, ZW,    5'd12},
		'{5'd14, 5'd15, ZW,    5'd9,  5'd10, 5'd11, ZW,    5'd13}
	};

	// Terms s1 and s2 count twice; d1 to d4 are subtracted.
	localparam logic [NTERM-1:0] TERM_DBL = 9'b0_0000_0110;
	localparam logic [NTERM-1:0] TERM_NEG = 9'b1_1110_0000;

	localparam logic [255:0] P256 =
		256'hFFFFFFFF00000001_0000000000000000_00000000FFFFFFFF_FFFFFFFFFFFFFFFF;

	typedef struct packed {
		logic [63:0] product_word;
		logic        product_last;
	} product_item_t;

	typedef struct packed {
		logic [63:0] result_word;
		logic        result_last;
	} result_item_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_ACC,
		ST_DECIDE,
		ST_PASS,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic       load_en;
		logic [2:0] load_idx;
		logic       clear;
		logic       step_en;
		logic       use_prime;
		logic       sub;
		logic [3:0] term;
		logic [2:0] col;
		logic       shift_out;
	} dp_ctrl_t;

	typedef struct packed {
		logic top_neg;
		logic top_zero;
	} dp_stat_t;

	function automatic logic [31:0] prime_chunk(input logic [2:0] col);
		prime_chunk = P256[col*32 +: 32];
	endfunction

endpackage

/* sv/p256_fast_reduction_core.sv */
// Top level of the NIST P-256 fast modular reduction core.
`timescale 1ns / 1ps

//  channel  | direction | payload         | transfer per item
//  product  | in        | product_item_t  | eight words, last mark on the eighth
//  result   | out       | result_item_t   | four words, last mark on the fourth
//
// The eight product words transfer at one per cycle into a register store. The
// reduction runs on one shared 32-bit add/subtract unit: the nine Solinas terms
// are accumulated over eight columns, then a decision state and one or more
// correction passes (adding or subtracting the prime) follow, with a decision
// after each pass. Reset clears the sequencer, the accumulator and its carries;
// the product store holds no valid data until written. Product stall is high
// from the last product word until the fourth result transfers, and a stalled
// result holds its word.

module p256_fast_reduction_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      product_valid,
	output logic                      product_stall,
	input  p256fr_pkg::product_item_t product,
	output logic                      result_valid,
	input  logic                      result_stall,
	output p256fr_pkg::result_item_t  result
);
	import p256fr_pkg::*;

	dp_ctrl_t    ctrl;
	dp_stat_t    stat;
	logic [63:0] result_word;
	logic        result_last;

	p256fr_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.product_valid (product_valid),
		.product_last  (product.product_last),
		.product_stall (product_stall),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result_last   (result_last),
		.stat          (stat),
		.ctrl          (ctrl)
	);

	p256fr_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.product_word (product.product_word),
		.stat         (stat),
		.result_word  (result_word)
	);

	assign result = {result_word, result_last};

`ifndef SYNTHESIS
	// The block never offers a result while it can take a product word.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(result_valid && !product_stall))
		else $error("result offered while product port is open");

	// A marked product word starts the reduction and closes the input side.
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(product_valid && !product_stall && product.product_last) |=> product_stall)
		else $error("product port open after last word");

	// The final result word reopens the input side.
	a_last_reopens: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_stall && result.result_last) |=> !product_stall)
		else $error("product port stalled after final result");

	// Emitted values lie in [0, 2^256): no carry above bit 255.
	a_carry_clear: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> stat.top_zero)
		else $error("carry above bit 255 while emitting");
`endif

endmodule

/* sv/p256fr_datapath.sv */
// Product store, shared 32-bit add/subtract unit and rotating accumulator.
`timescale 1ns / 1ps

module p256fr_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  p256fr_pkg::dp_ctrl_t ctrl,
	input  logic [63:0]          product_word,
	output p256fr_pkg::dp_stat_t stat,
	output logic [63:0]          result_word
);
	import p256fr_pkg::*;

	logic [63:0]        store_q [NCOL];
	logic [31:0]        acc_q [NCOL];
	logic signed [3:0]  top_q;
	logic signed [2:0]  cy_q;

	logic [4:0]         src;
	logic [63:0]        rd_word;
	logic [31:0]        a32;
	logic [32:0]        op_mag;
	logic               neg;
	logic signed [35:0] op_s;
	logic signed [35:0] sum;
	logic [2:0]         cy_n;

	always_comb begin
		src     = TERM_SRC[ctrl.term][ctrl.col];
		rd_word = store_q[src[3:1]];
		if (src[4]) begin
			a32 = '0;
		end else if (src[0]) begin
			a32 = rd_word[63:32];
		end else begin
			a32 = rd_word[31:0];
		end
		if (ctrl.use_prime) begin
			op_mag = {1'b0, prime_chunk(ctrl.col)};
			neg    = ctrl.sub;
		end else begin
			op_mag = TERM_DBL[ctrl.term] ? {a32, 1'b0} : {1'b0, a32};
			neg    = TERM_NEG[ctrl.term];
		end
		op_s = neg ? -$signed({3'b000, op_mag}) : $signed({3'b000, op_mag});
		// Column 0 of the rotating accumulator is always the column being worked on.
		sum  = $signed({4'b0000, acc_q[0]}) + op_s + $signed({{33{cy_q[2]}}, cy_q});
		cy_n = sum[34:32];
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_en) begin
			store_q[ctrl.load_idx] <= product_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCOL; i++) begin
				acc_q[i] <= '0;
			end
			top_q <= '0;
			cy_q  <= '0;
		end else if (ctrl.clear) begin
			for (int i = 0; i < NCOL; i++) begin
				acc_q[i] <= '0;
			end
			top_q <= '0;
			cy_q  <= '0;
		end else if (ctrl.step_en) begin
			for (int i = 0; i < NCOL - 1; i++) begin
				acc_q[i] <= acc_q[i+1];
			end
			acc_q[NCOL-1] <= sum[31:0];
			if (ctrl.col == LAST_COL) begin
				top_q <= top_q + $signed({cy_n[2], cy_n});
				cy_q  <= '0;
			end else begin
				cy_q <= cy_n;
			end
		end else if (ctrl.shift_out) begin
			for (int i = 0; i < NCOL - 2; i++) begin
				acc_q[i] <= acc_q[i+2];
			end
			acc_q[NCOL-2] <= acc_q[0];
			acc_q[NCOL-1] <= acc_q[1];
		end
	end

	assign stat.top_neg  = top_q[3];
	assign stat.top_zero = (top_q == 4'sd0);
	assign result_word   = {acc_q[1], acc_q[0]};

endmodule

/* sv/p256fr_ctrl.sv */
// Sequencer that loads the product, schedules the term and correction passes and emits.
`timescale 1ns / 1ps

module p256fr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 product_valid,
	input  logic                 product_last,
	output logic                 product_stall,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic                 result_last,
	input  p256fr_pkg::dp_stat_t stat,
	output p256fr_pkg::dp_ctrl_t ctrl
);
	import p256fr_pkg::*;

	state_t     state_q, state_n;
	logic [2:0] load_cnt_q;
	logic [3:0] term_q;
	logic [2:0] col_q;
	logic       add_q;
	logic [1:0] emit_q;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (product_valid && product_last) begin
					state_n = ST_ACC;
				end
			end
			ST_ACC: begin
				if (term_q == LAST_TERM && col_q == LAST_COL) begin
					state_n = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (stat.top_neg || !add_q) begin
					state_n = ST_PASS;
				end else begin
					state_n = ST_EMIT;
				end
			end
			ST_PASS: begin
				if (col_q == LAST_COL) begin
					state_n = ST_DECIDE;
				end
			end
			ST_EMIT: begin
				if (!result_stall && emit_q == LAST_EMIT) begin
					state_n = ST_LOAD;
				end
			end
			default: state_n = ST_LOAD;
		endcase
	end

	always_comb begin
		product_stall  = (state_q != ST_LOAD);
		result_valid   = (state_q == ST_EMIT);
		result_last    = (emit_q == LAST_EMIT);
		ctrl.load_en   = (state_q == ST_LOAD) && product_valid;
		ctrl.load_idx  = load_cnt_q;
		ctrl.clear     = (state_q == ST_LOAD) && product_valid && product_last;
		ctrl.step_en   = (state_q == ST_ACC) || (state_q == ST_PASS);
		ctrl.use_prime = (state_q == ST_PASS);
		ctrl.sub       = !add_q;
		ctrl.term      = term_q;
		ctrl.col       = col_q;
		ctrl.shift_out = (state_q == ST_EMIT) && !result_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			load_cnt_q <= '0;
			term_q     <= '0;
			col_q      <= '0;
			add_q      <= 1'b0;
			emit_q     <= '0;
		end else begin
			state_q <= state_n;
			if (ctrl.load_en) begin
				load_cnt_q <= product_last ? 3'd0 : load_cnt_q + 3'd1;
			end
			if (ctrl.clear) begin
				term_q <= '0;
				col_q  <= '0;
				add_q  <= 1'b0;
				emit_q <= '0;
			end
			if (ctrl.step_en) begin
				col_q <= col_q + 3'd1;
			end
			if (state_q == ST_ACC && col_q == LAST_COL && term_q != LAST_TERM) begin
				term_q <= term_q + 4'd1;
			end
			// A pass adds the prime while the value is negative and subtracts it otherwise.
			if (state_q == ST_DECIDE && (stat.top_neg || !add_q)) begin
				add_q <= stat.top_neg;
			end
			if (ctrl.shift_out) begin
				emit_q <= emit_q + 2'd1;
			end
		end
	end

endmodule
